// File: hw/rtl/lpr_pkg.sv
// Package for the lens position ramp: types, constants and the microcode program.
package lpr_pkg;

  localparam int PosW = 10;
  localparam int PcW  = 5;

  // Arithmetic is done one bit wider so that position plus a step cannot wrap.
  localparam logic [PosW:0]   RISE_STEP     = 11'd50;
  localparam logic [PosW:0]   FALL_STEP     = 11'd150;
  localparam logic [PosW:0]   PARK_STEP     = 11'd50;
  localparam logic [PosW:0]   HIGH_JUMP     = 11'd800;
  localparam logic [PosW:0]   LOW_JUMP      = 11'd300;
  localparam logic [PosW-1:0] READ_FAIL_POS = 10'd508;

  localparam logic [PosW-1:0] INF_LIMIT_RST   = 10'd0;
  localparam logic [PosW-1:0] MACRO_LIMIT_RST = 10'd1023;

  // Command codes.
  localparam logic [1:0] OP_OPEN    = 2'd0;
  localparam logic [1:0] OP_MOVE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_INF_LIMIT   = 1'b0;
  localparam logic REG_MACRO_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_OPENED = 2'd1,
    ST_ACTIVE = 2'd2
  } open_state_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_IDLE  = 2'd2
  } status_t;

  // Condition tested by a step; a true condition (after inversion) takes the jump.
  typedef enum logic [4:0] {
    C_NEVER,
    C_ALWAYS,
    C_OP_OPEN,
    C_OP_MOVE,
    C_OP_RELEASE,
    C_CLOSED,
    C_OPENED,
    C_ACTIVE,
    C_OUT_RANGE,
    C_CUR_EQ_TGT,
    C_TGT_LT_CUR,
    C_RISE_FAR,
    C_FALL_FAR,
    C_CUR_LT_PARK,
    C_CUR_GT_PARK,
    C_CUR_GT_HIGH,
    C_CUR_LT_LOW,
    C_ABOVE_PARK_FAR,
    C_BELOW_PARK_FAR
  } cond_t;

  typedef enum logic [1:0] {
    A_NONE,
    A_WAIT,
    A_EMIT,
    A_FIRST
  } act_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_CUR_UP,
    K_CUR_FALL,
    K_CUR_PARK_DOWN,
    K_TARGET,
    K_PARK,
    K_HIGH,
    K_LOW
  } code_sel_t;

  typedef enum logic [1:0] {
    OS_KEEP,
    OS_OPEN,
    OS_CLOSE
  } open_set_t;

  typedef struct packed {
    cond_t            cond;
    logic             inv;
    logic [PcW-1:0]   jump;
    act_t             act;
    code_sel_t        code;
    status_t          status;
    logic             last;
    open_set_t        open_set;
  } ucode_t;

  // What the datapath reports back to the sequencer for the current step.
  typedef struct packed {
    logic             cond_hit;
    logic             drive_valid;
    logic [PosW-1:0]  drive_code;
    logic [PosW-1:0]  position;
  } dp_status_t;

  function automatic ucode_t uw(cond_t c, logic inv, logic [PcW-1:0] jump, act_t act,
                                code_sel_t code, status_t st, logic last, open_set_t os);
    ucode_t w;
    w.cond     = c;
    w.inv      = inv;
    w.jump     = jump;
    w.act      = act;
    w.code     = code;
    w.status   = st;
    w.last     = last;
    w.open_set = os;
    return w;
  endfunction

  // The control program. Step 0 waits for a command; every path ends with a jump back.
  function automatic ucode_t lpr_ucode(logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      // dispatch
      5'd0:  w = uw(C_NEVER,          1'b0, 5'd0,  A_WAIT,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd1:  w = uw(C_OP_OPEN,        1'b0, 5'd5,  A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd2:  w = uw(C_OP_MOVE,        1'b0, 5'd7,  A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd3:  w = uw(C_OP_RELEASE,     1'b0, 5'd18, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd4:  w = uw(C_ALWAYS,         1'b0, 5'd0,  A_EMIT,  K_NONE,  STATUS_IDLE, 1'b1, OS_KEEP);
      // open
      5'd5:  w = uw(C_CLOSED,         1'b1, 5'd4,  A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd6:  w = uw(C_ALWAYS,         1'b0, 5'd0,  A_EMIT,  K_NONE,  STATUS_OK,   1'b1, OS_OPEN);
      // move
      5'd7:  w = uw(C_OUT_RANGE,      1'b1, 5'd9,  A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd8:  w = uw(C_ALWAYS,         1'b0, 5'd0,  A_EMIT,  K_NONE,  STATUS_RANGE,1'b1, OS_KEEP);
      5'd9:  w = uw(C_OPENED,         1'b1, 5'd11, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd10: w = uw(C_NEVER,          1'b0, 5'd0,  A_FIRST, K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd11: w = uw(C_CUR_EQ_TGT,     1'b0, 5'd4,  A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd12: w = uw(C_TGT_LT_CUR,     1'b0, 5'd15, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd13: w = uw(C_RISE_FAR,       1'b1, 5'd17, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd14: w = uw(C_ALWAYS,         1'b0, 5'd13, A_EMIT,  K_CUR_UP,STATUS_OK,   1'b0, OS_KEEP);
      5'd15: w = uw(C_FALL_FAR,       1'b1, 5'd17, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd16: w = uw(C_ALWAYS,         1'b0, 5'd15, A_EMIT,  K_CUR_FALL, STATUS_OK, 1'b0, OS_KEEP);
      5'd17: w = uw(C_ALWAYS,         1'b0, 5'd0,  A_EMIT,  K_TARGET, STATUS_OK,  1'b1, OS_KEEP);
      // release
      5'd18: w = uw(C_ACTIVE,         1'b0, 5'd20, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd19: w = uw(C_ALWAYS,         1'b0, 5'd0,  A_EMIT,  K_NONE,  STATUS_IDLE, 1'b1, OS_CLOSE);
      5'd20: w = uw(C_CUR_LT_PARK,    1'b0, 5'd26, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd21: w = uw(C_CUR_GT_PARK,    1'b1, 5'd30, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd22: w = uw(C_CUR_GT_HIGH,    1'b1, 5'd24, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd23: w = uw(C_NEVER,          1'b0, 5'd0,  A_EMIT,  K_HIGH,  STATUS_OK,   1'b0, OS_KEEP);
      5'd24: w = uw(C_ABOVE_PARK_FAR, 1'b1, 5'd30, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd25: w = uw(C_ALWAYS,         1'b0, 5'd24, A_EMIT,  K_CUR_PARK_DOWN, STATUS_OK, 1'b0,
                    OS_KEEP);
      5'd26: w = uw(C_CUR_LT_LOW,     1'b1, 5'd28, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd27: w = uw(C_NEVER,          1'b0, 5'd0,  A_EMIT,  K_LOW,   STATUS_OK,   1'b0, OS_KEEP);
      5'd28: w = uw(C_BELOW_PARK_FAR, 1'b1, 5'd30, A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
      5'd29: w = uw(C_ALWAYS,         1'b0, 5'd28, A_EMIT,  K_CUR_UP,STATUS_OK,   1'b0, OS_KEEP);
      5'd30: w = uw(C_ALWAYS,         1'b0, 5'd0,  A_EMIT,  K_PARK,  STATUS_OK,   1'b1, OS_CLOSE);
      default: w = uw(C_ALWAYS,       1'b0, 5'd0,  A_NONE,  K_NONE,  STATUS_OK,   1'b0, OS_KEEP);
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/lens_position_ramp.sv
// Top level of the lens position ramp: command channel, microcode sequencer and result register.
//
// Commands arrive on the s_ stream group, one transfer per command: open, move or
// release, with the move target and the device readback taken at the first move.
// Every command answers with one or more result transfers on the m_ group; the final
// one carries tlast. A result with drive_valid set is a code to write to the actuator,
// otherwise it only reports status (ok, out of range or nothing to do).
// The limits inf_limit and macro_limit sit behind the APB-style port at 0x0 and 0x4.
// Control runs from a 31-step program held in a constant table. Each step tests one
// condition and either jumps or falls through; steps that emit a result wait until
// the result register is free. A command passes through the wait step that takes the
// transfer, one to three dispatch steps, up to five setup steps, then a test step and
// an emit step per ramp write and a test and an emit step for the final write. A
// full-scale rise takes 21 writes. s_tready is high only in the wait step, which is
// reentered as the last result of a command is loaded, so commands are handled one
// at a time. When the receiver stalls, the result register holds its transfer and the
// sequencer halts on its next emit step; nothing is dropped.
// Reset clears the program counter, the result valid flag, the tracked and park
// positions, the open state and the limits (0 and 1023).
module lens_position_ramp (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // target_position, readback_position, readback_ok, zero fill
  input  logic [1:0]  s_tuser,   // op
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // drive_code, current_position, zero fill
  output logic [2:0]  m_tuser,   // drive_valid, status
  output logic        m_tlast,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpr_pkg::*;

  logic [PcW-1:0]  pc;
  logic [PcW-1:0]  pc_next;
  ucode_t          word;
  logic            fire;
  logic            out_free;
  dp_status_t      dp;

  logic [PosW-1:0] inf_limit;
  logic [PosW-1:0] macro_limit;

  logic [PosW-1:0] out_code;
  logic [PosW-1:0] out_position;
  logic            out_drive_valid;
  status_t         out_status;
  logic            out_last;

  // Configuration registers; the word address picks the register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inf_limit   <= INF_LIMIT_RST;
      macro_limit <= MACRO_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_INF_LIMIT) begin
        inf_limit <= pwdata[PosW-1:0];
      end else begin
        macro_limit <= pwdata[PosW-1:0];
      end
    end
  end

  assign prdata = {22'd0, (paddr[2] == REG_MACRO_LIMIT) ? macro_limit : inf_limit};

  // Sequencer: fetch, decide whether the step may complete, then jump or fall through.
  assign word     = lpr_ucode(pc);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (word.act == A_WAIT);

  always_comb begin
    unique case (word.act)
      A_WAIT:  fire = s_tvalid;
      A_EMIT:  fire = out_free;
      A_FIRST: fire = 1'b1;
      A_NONE:  fire = 1'b1;
      default: fire = 1'b1;
    endcase
    pc_next = pc;
    if (fire) begin
      pc_next = dp.cond_hit ? word.jump : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  lpr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .word           (word),
    .fire           (fire),
    .in_op          (s_tuser),
    .in_target      (s_tdata[9:0]),
    .in_readback    (s_tdata[19:10]),
    .in_readback_ok (s_tdata[20]),
    .inf_limit      (inf_limit),
    .macro_limit    (macro_limit),
    .dp             (dp)
  );

  // Result register: loaded by an emit step, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && word.act == A_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && word.act == A_EMIT) begin
      out_drive_valid <= dp.drive_valid;
      out_code        <= dp.drive_valid ? dp.drive_code : '0;
      out_position    <= dp.position;
      out_status      <= word.status;
      out_last        <= word.last;
    end
  end

  assign m_tdata = {4'd0, out_position, out_code};
  assign m_tuser = {out_status, out_drive_valid};
  assign m_tlast = out_last;

endmodule

// File: hw/rtl/lpr_datapath.sv
// Datapath of the lens position ramp: position state, condition flags and code selection.
module lpr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lpr_pkg::ucode_t             word,
  input  logic                        fire,
  input  logic [1:0]                  in_op,
  input  logic [lpr_pkg::PosW-1:0]    in_target,
  input  logic [lpr_pkg::PosW-1:0]    in_readback,
  input  logic                        in_readback_ok,
  input  logic [lpr_pkg::PosW-1:0]    inf_limit,
  input  logic [lpr_pkg::PosW-1:0]    macro_limit,
  output lpr_pkg::dp_status_t         dp
);
  import lpr_pkg::*;

  logic [PosW-1:0] op_reg;
  logic [PosW-1:0] target;
  logic [PosW-1:0] readback;
  logic            readback_ok;
  logic [1:0]      op;
  logic [PosW-1:0] cur;
  logic [PosW-1:0] park;
  open_state_t     open_state;

  logic [PosW:0]   cur_w;
  logic [PosW:0]   tgt_w;
  logic [PosW:0]   park_w;
  logic            cond_raw;
  logic [PosW:0]   code_w;
  logic            code_valid;

  assign op_reg = '0;
  assign cur_w  = {1'b0, cur};
  assign tgt_w  = {1'b0, target};
  assign park_w = {1'b0, park};

  always_comb begin
    unique case (word.cond)
      C_NEVER:          cond_raw = 1'b0;
      C_ALWAYS:         cond_raw = 1'b1;
      C_OP_OPEN:        cond_raw = (op == OP_OPEN);
      C_OP_MOVE:        cond_raw = (op == OP_MOVE);
      C_OP_RELEASE:     cond_raw = (op == OP_RELEASE);
      C_CLOSED:         cond_raw = (open_state == ST_CLOSED);
      C_OPENED:         cond_raw = (open_state == ST_OPENED);
      C_ACTIVE:         cond_raw = (open_state == ST_ACTIVE);
      C_OUT_RANGE:      cond_raw = (target > macro_limit) || (target < inf_limit);
      C_CUR_EQ_TGT:     cond_raw = (cur == target);
      C_TGT_LT_CUR:     cond_raw = (target < cur);
      C_RISE_FAR:       cond_raw = (tgt_w > cur_w + RISE_STEP);
      C_FALL_FAR:       cond_raw = (cur_w > tgt_w + FALL_STEP);
      C_CUR_LT_PARK:    cond_raw = (cur < park);
      C_CUR_GT_PARK:    cond_raw = (cur > park);
      C_CUR_GT_HIGH:    cond_raw = (cur_w > HIGH_JUMP);
      C_CUR_LT_LOW:     cond_raw = (cur_w < LOW_JUMP);
      C_ABOVE_PARK_FAR: cond_raw = (cur_w > park_w + PARK_STEP);
      C_BELOW_PARK_FAR: cond_raw = (cur_w + PARK_STEP < park_w);
      default:          cond_raw = 1'b0;
    endcase
  end

  // The program only steps when the result stays in range, so the low bits are the code.
  always_comb begin
    code_valid = 1'b1;
    unique case (word.code)
      K_NONE:          begin code_w = '0; code_valid = 1'b0; end
      K_CUR_UP:        code_w = cur_w + RISE_STEP;
      K_CUR_FALL:      code_w = cur_w - FALL_STEP;
      K_CUR_PARK_DOWN: code_w = cur_w - PARK_STEP;
      K_TARGET:        code_w = tgt_w;
      K_PARK:          code_w = park_w;
      K_HIGH:          code_w = HIGH_JUMP;
      K_LOW:           code_w = LOW_JUMP;
      default:         begin code_w = '0; code_valid = 1'b0; end
    endcase
  end

  assign dp.cond_hit    = cond_raw ^ word.inv;
  assign dp.drive_valid = code_valid;
  assign dp.drive_code  = code_w[PosW-1:0] | op_reg;
  assign dp.position    = code_valid ? code_w[PosW-1:0] : cur;

  // Command fields are captured when the wait step takes a transfer.
  always_ff @(posedge clk) begin
    if (fire && word.act == A_WAIT) begin
      op          <= in_op;
      target      <= in_target;
      readback    <= in_readback;
      readback_ok <= in_readback_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      park       <= '0;
      open_state <= ST_CLOSED;
    end else if (fire) begin
      if (word.act == A_FIRST) begin
        park       <= target;
        cur        <= readback_ok ? readback : READ_FAIL_POS;
        open_state <= ST_ACTIVE;
      end else if (word.act == A_EMIT && code_valid) begin
        cur <= code_w[PosW-1:0];
      end
      if (word.open_set == OS_OPEN) begin
        open_state <= ST_OPENED;
      end else if (word.open_set == OS_CLOSE) begin
        open_state <= ST_CLOSED;
      end
    end
  end

endmodule

// File: hw/rtl/lpr_checker.sv
// Port-level checks for the lens position ramp and the bind that attaches them.
module lpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // A drive write always reports ok status.
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[2:1] == 2'd0)
    else $error("drive write with nonzero status");

  // A status-only result ends its command and carries a zero code.
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[9:0] == 10'd0)
    else $error("status-only result not final or with a code");

  // After a drive write the tracked position is the written code.
  a_track: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[19:10] == m_tdata[9:0])
    else $error("tracked position differs from written code");

endmodule

bind lens_position_ramp lpr_checker u_lpr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
